[design/lbrl_pkg.sv]
// Package: shared types, codes and defaults of the leaky bucket rate limiter.
`timescale 1ns / 1ps
package lbrl_pkg;

  localparam int BUCKET_COUNT_DEF       = 1024;
  localparam int NUM_ACTIVITY_TYPES_DEF = 4;
  localparam int DATA_W                 = 32;
  localparam int CFG_W                  = 64;
  localparam int CFG_IDX_W              = 3;
  localparam int WORD_W                 = 2 * DATA_W + 1;

  localparam logic [1:0] CMD_CHECK = 2'd0;
  localparam logic [1:0] CMD_QUERY = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLED    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_TOKENS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_THR  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ALERT_THR  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TOKENS_PI  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_COSTS      = 3'd6;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [9:0]        bucket_index;
    logic [1:0]        activity_type;
    logic [DATA_W-1:0] now;
  } in_t;

  typedef struct packed {
    logic              allowed;
    logic              newly_blocked;
    logic              alert_crossed;
    logic              unblocked;
    logic [DATA_W-1:0] tokens_after;
    logic [DATA_W-1:0] blocked_until;
    logic              found;
  } out_t;

endpackage

[design/lbrl_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps
module lbrl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/lbrl_divider.sv]
// Restoring 32-bit unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module lbrl_divider import lbrl_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              go,
  input  logic [DATA_W-1:0] dividend,
  input  logic [DATA_W-1:0] divisor,
  output logic              done,
  output logic [DATA_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DATA_W + 1);

  logic              run_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [DATA_W:0]   rem_r;
  logic [DATA_W-1:0] quo_r;
  logic [DATA_W-1:0] dsr_r;
  logic              done_r;
  logic [DATA_W:0]   rem_sh;
  logic              fits;

  // divisor of zero: every step fits, quotient all ones
  assign rem_sh = {rem_r[DATA_W-1:0], quo_r[DATA_W-1]};
  assign fits   = rem_sh >= {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        run_r <= 1'b1;
        cnt_r <= CNT_W'(DATA_W);
        rem_r <= '0;
        quo_r <= dividend;
        dsr_r <= divisor;
      end else if (run_r) begin
        rem_r <= fits ? rem_sh - {1'b0, dsr_r} : rem_sh;
        quo_r <= {quo_r[DATA_W-2:0], fits};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

[design/leaky_bucket_rate_limiter_unit.sv]
// Top level: per-key leaky bucket rate limiter, one tier.
`timescale 1ns / 1ps
// Usage:
//  Input: a transaction is taken at a clock edge with start high and busy low;
//  in_data carries cmd (check, query, clear), bucket_index, activity_type, now.
//  Output: one result per transaction, on out_data for exactly one cycle with
//  out_valid high. The receiver cannot stall; the result is simply presented.
//  Configuration: cfg_we with cfg_index/cfg_data writes one register per edge;
//  the user must write only while idle, the block itself does not enforce it.
//  Sequence after acceptance: read, evaluate, then write-back for clear, the
//  unused command and a disabled check; a check or query that needs no decay
//  (no bucket or an empty one) passes the activity step before write-back;
//  when decay applies, the 32-step divider first forms the elapsed interval
//  count; a query on a blocked key adds a second division for the block end.
//  The next transaction can be taken at the edge that ends the strobe cycle.
//  One transaction is in flight at a time; busy stays high until its strobe.
//  State: one RAM word per bucket {valid, tokens, stamp}, read, modified in
//  registers and written back in the last cycle, so no forwarding is needed.
//  Reset: registers take their defaults, then a clearing pass writes every
//  bucket word to zero, one per cycle, with busy high.
module leaky_bucket_rate_limiter_unit import lbrl_pkg::*; #(
  parameter int BUCKET_COUNT       = BUCKET_COUNT_DEF,
  parameter int NUM_ACTIVITY_TYPES = NUM_ACTIVITY_TYPES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  in_t                  in_data,
  output logic                 out_valid,
  output out_t                 out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int IDX_W = $clog2(BUCKET_COUNT);

  typedef enum logic [3:0] {
    ST_CLR, ST_IDLE, ST_RD, ST_EVAL, ST_DIVA, ST_MUL1, ST_MUL2,
    ST_DEC, ST_ACT, ST_QMUL, ST_DIVB, ST_WB
  } state_t;

  state_t state_r;

  // configuration registers
  logic              enabled_r;
  logic [DATA_W-1:0] max_tok_r, block_thr_r, alert_thr_r, interval_r, tpi_r;
  logic [CFG_W-1:0]  costs_r;

  // transaction context
  in_t               item_r;
  logic [IDX_W-1:0]  idx_r;
  logic              found_r;
  logic [DATA_W-1:0] tok_r, time_r, n_r, refund_r;
  logic              ub_r;
  out_t              out_r;
  logic              out_valid_r;
  logic              wb_en_r;
  logic [WORD_W-1:0] wb_word_r;
  logic [IDX_W-1:0]  clr_cnt_r;

  // divider handshake
  logic              div_go_r;
  logic [DATA_W-1:0] div_a_r, div_b_r;
  logic              div_done;
  logic [DATA_W-1:0] div_q;

  // RAM ports
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr, mem_raddr;
  logic [WORD_W-1:0] mem_wdata, mem_rdata;

  logic [IDX_W-1:0]  in_idx;
  assign in_idx = IDX_W'(in_data.bucket_index % BUCKET_COUNT);

  assign mem_raddr = in_idx;

  always_comb begin
    if (state_r == ST_CLR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_r;
      mem_wdata = '0;
    end else begin
      mem_we    = (state_r == ST_WB) && wb_en_r;
      mem_waddr = idx_r;
      mem_wdata = wb_word_r;
    end
  end

  lbrl_ram #(.WIDTH(WORD_W), .DEPTH(BUCKET_COUNT)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  lbrl_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (div_go_r),
    .dividend (div_a_r),
    .divisor  (div_b_r),
    .done     (div_done),
    .quotient (div_q)
  );

  // cost of the activity; types past the configured count cost nothing
  logic [15:0]         cost_raw;
  logic signed [33:0]  cost_ext, sum;
  logic [DATA_W-1:0]   last, charged, decayed;

  assign cost_raw = (32'(item_r.activity_type) < NUM_ACTIVITY_TYPES) ?
                    costs_r[16*item_r.activity_type +: 16] : 16'd0;
  assign cost_ext = 34'(signed'(cost_raw));
  assign last     = found_r ? tok_r : '0;
  assign sum      = signed'({2'b00, last}) + cost_ext;

  always_comb begin
    if (sum < 0) begin
      charged = '0;
    end else if (sum[DATA_W:0] > {1'b0, max_tok_r}) begin
      charged = max_tok_r;
    end else begin
      charged = sum[DATA_W-1:0];
    end
  end

  assign decayed = (refund_r > tok_r) ? '0 : tok_r - refund_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      div_go_r    <= 1'b0;
      wb_en_r     <= 1'b0;
      enabled_r   <= 1'b1;
      max_tok_r   <= 32'd1000;
      block_thr_r <= 32'd100;
      alert_thr_r <= 32'd50;
      interval_r  <= 32'd1;
      tpi_r       <= 32'd1;
      costs_r     <= '0;
    end else begin
      out_valid_r <= 1'b0;
      div_go_r    <= 1'b0;

      if (cfg_we) begin
        case (cfg_index)
          REG_ENABLED:    enabled_r   <= cfg_data[0];
          REG_MAX_TOKENS: max_tok_r   <= cfg_data[DATA_W-1:0];
          REG_BLOCK_THR:  block_thr_r <= cfg_data[DATA_W-1:0];
          REG_ALERT_THR:  alert_thr_r <= cfg_data[DATA_W-1:0];
          REG_INTERVAL:   interval_r  <= cfg_data[DATA_W-1:0];
          REG_TOKENS_PI:  tpi_r       <= cfg_data[DATA_W-1:0];
          REG_COSTS:      costs_r     <= cfg_data;
          default: ;
        endcase
      end

      case (state_r)
        ST_CLR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == IDX_W'(BUCKET_COUNT - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start) begin
            item_r  <= in_data;
            idx_r   <= in_idx;
            state_r <= ST_RD;
          end
        end
        ST_RD: begin
          found_r <= mem_rdata[WORD_W-1];
          tok_r   <= mem_rdata[2*DATA_W-1:DATA_W];
          time_r  <= mem_rdata[DATA_W-1:0];
          state_r <= ST_EVAL;
        end
        ST_EVAL: begin
          out_r   <= '0;
          ub_r    <= 1'b0;
          wb_en_r <= 1'b0;
          case (item_r.cmd)
            CMD_CHECK, CMD_QUERY: begin
              if (item_r.cmd == CMD_CHECK && !enabled_r) begin
                out_r.allowed      <= 1'b1;
                out_r.found        <= found_r;
                out_r.tokens_after <= found_r ? tok_r : '0;
                state_r            <= ST_WB;
              end else if (found_r && tok_r != '0) begin
                div_a_r  <= item_r.now - time_r;
                div_b_r  <= interval_r;
                div_go_r <= 1'b1;
                state_r  <= ST_DIVA;
              end else begin
                state_r <= ST_ACT;
              end
            end
            CMD_CLEAR: begin
              out_r.allowed <= 1'b1;
              out_r.found   <= found_r;
              wb_en_r       <= found_r;
              wb_word_r     <= {1'b1, {DATA_W{1'b0}}, item_r.now};
              state_r       <= ST_WB;
            end
            default: begin
              state_r <= ST_WB;
            end
          endcase
        end
        ST_DIVA: begin
          if (div_done) begin
            n_r     <= div_q;
            state_r <= ST_MUL1;
          end
        end
        ST_MUL1: begin
          time_r  <= time_r + DATA_W'(n_r * interval_r);
          state_r <= ST_MUL2;
        end
        ST_MUL2: begin
          refund_r <= DATA_W'(n_r * tpi_r);
          state_r  <= ST_DEC;
        end
        ST_DEC: begin
          tok_r   <= decayed;
          ub_r    <= (tok_r >= block_thr_r) && (decayed < block_thr_r);
          state_r <= ST_ACT;
        end
        ST_ACT: begin
          out_r.found     <= found_r;
          out_r.unblocked <= ub_r;
          if (item_r.cmd == CMD_CHECK) begin
            if (cost_raw == 16'd0) begin
              // test only: no bucket is created
              out_r.allowed      <= !(found_r && tok_r >= block_thr_r);
              out_r.tokens_after <= last;
              wb_en_r            <= found_r;
              wb_word_r          <= {1'b1, tok_r, time_r};
            end else begin
              out_r.allowed       <= charged < block_thr_r;
              out_r.newly_blocked <= (charged >= block_thr_r) && (last < block_thr_r);
              out_r.alert_crossed <= (charged >= alert_thr_r) && (last < alert_thr_r);
              out_r.tokens_after  <= charged;
              wb_en_r             <= 1'b1;
              wb_word_r           <= {1'b1, charged, item_r.now};
            end
            state_r <= ST_WB;
          end else begin
            wb_en_r   <= found_r;
            wb_word_r <= {1'b1, tok_r, time_r};
            out_r.tokens_after <= last;
            if (found_r && tok_r >= block_thr_r) begin
              state_r <= ST_QMUL;
            end else begin
              out_r.allowed <= 1'b1;
              state_r       <= ST_WB;
            end
          end
        end
        ST_QMUL: begin
          div_a_r  <= DATA_W'((tok_r - block_thr_r + 1'b1) * interval_r);
          div_b_r  <= tpi_r;
          div_go_r <= 1'b1;
          state_r  <= ST_DIVB;
        end
        ST_DIVB: begin
          if (div_done) begin
            out_r.allowed       <= 1'b0;
            out_r.blocked_until <= time_r + div_q;
            state_r             <= ST_WB;
          end
        end
        ST_WB: begin
          out_valid_r <= 1'b1;
          state_r     <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy      = state_r != ST_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[verif/leaky_bucket_rate_limiter_unit_tb.sv]
// Testbench: directed and random command streams against a predictor of the bucket table.
`timescale 1ns / 1ps
module leaky_bucket_rate_limiter_unit_tb;
  import lbrl_pkg::*;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  in_t                  in_data;
  logic                 out_valid;
  out_t                 out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  leaky_bucket_rate_limiter_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor copy of the configuration registers
  logic        lim_enabled;
  logic [31:0] lim_max;
  logic [31:0] lim_block;
  logic [31:0] lim_alert;
  logic [31:0] lim_interval;
  logic [31:0] lim_tpi;
  logic [63:0] lim_costs;

  // Predictor copy of the bucket table
  logic        tbl_valid [1024];
  logic [31:0] tbl_tokens[1024];
  logic [31:0] tbl_stamp [1024];

  out_t verdict_q[$];
  int   mismatches;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Safety net: the timeout covers the slowest latency plus idle gap per item,
  // plus the clearing pass, and allows many times that.
  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic [31:0] div_or_ones(logic [31:0] a, logic [31:0] b);
    return (b == 32'd0) ? 32'hFFFF_FFFF : a / b;
  endfunction

  // Leak whole elapsed intervals from one bucket; returns 1 when it drops below block level
  function automatic logic leak_bucket(int idx, logic [31:0] t_now);
    logic [31:0] prior, n, refund;
    if (!tbl_valid[idx] || tbl_tokens[idx] == 32'd0) return 1'b0;
    prior = tbl_tokens[idx];
    n = div_or_ones(t_now - tbl_stamp[idx], lim_interval);
    tbl_stamp[idx] = tbl_stamp[idx] + n * lim_interval;
    refund = n * lim_tpi;
    tbl_tokens[idx] = (refund > prior) ? 32'd0 : prior - refund;
    return (prior >= lim_block) && (tbl_tokens[idx] < lim_block);
  endfunction

  function automatic out_t predict_verdict(in_t tr);
    out_t        v;
    int          idx;
    logic signed [63:0] cost, sum;
    logic [31:0] last, span;
    v = '0;
    idx = int'(tr.bucket_index);
    v.found = tbl_valid[idx];
    case (tr.cmd)
      CMD_CHECK: begin
        v.allowed = 1'b1;
        if (!lim_enabled) begin
          v.tokens_after = v.found ? tbl_tokens[idx] : 32'd0;
        end else begin
          cost = 64'(signed'(lim_costs[16*tr.activity_type +: 16]));
          v.unblocked = leak_bucket(idx, tr.now);
          if (cost == 0) begin
            if (v.found && tbl_tokens[idx] >= lim_block) v.allowed = 1'b0;
            v.tokens_after = v.found ? tbl_tokens[idx] : 32'd0;
          end else begin
            if (!v.found) begin
              tbl_valid[idx] = 1'b1;
              tbl_tokens[idx] = 32'd0;
            end
            last = tbl_tokens[idx];
            tbl_stamp[idx] = tr.now;
            sum = $signed({32'd0, last}) + cost;
            if (sum < 0) sum = 0;
            if (sum > $signed({32'd0, lim_max})) sum = $signed({32'd0, lim_max});
            v.tokens_after = sum[31:0];
            tbl_tokens[idx] = sum[31:0];
            v.alert_crossed = (sum[31:0] >= lim_alert) && (last < lim_alert);
            if (sum[31:0] >= lim_block) begin
              v.allowed = 1'b0;
              v.newly_blocked = last < lim_block;
            end
          end
        end
      end
      CMD_QUERY: begin
        v.allowed = 1'b1;
        v.unblocked = leak_bucket(idx, tr.now);
        if (v.found) begin
          v.tokens_after = tbl_tokens[idx];
          if (tbl_tokens[idx] >= lim_block) begin
            span = (tbl_tokens[idx] - lim_block + 32'd1) * lim_interval;
            v.allowed = 1'b0;
            v.blocked_until = tbl_stamp[idx] + div_or_ones(span, lim_tpi);
          end
        end
      end
      CMD_CLEAR: begin
        v.allowed = 1'b1;
        if (v.found) begin
          tbl_tokens[idx] = 32'd0;
          tbl_stamp[idx] = tr.now;
        end
      end
      default: v = '0;
    endcase
    return v;
  endfunction

  // Result checker: every strobe is matched against the oldest prediction
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid) begin
      if (verdict_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_data);
      end else begin
        want = verdict_q.pop_front();
        if (out_data !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, out_data);
        end
      end
    end
  end

  // Send one transaction: optional idle gap, then hold start until accepted.
  // With no gap start stays high from the previous transaction.
  task automatic send_cmd(logic [1:0] cmd, logic [9:0] idx, logic [1:0] atype,
                          logic [31:0] t_now);
    in_t tr;
    int  gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    tr.cmd = cmd;
    tr.bucket_index = idx;
    tr.activity_type = atype;
    tr.now = t_now;
    in_data <= tr;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    verdict_q.push_back(predict_verdict(tr));
    @(negedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (verdict_q.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_ENABLED:    lim_enabled  = val[0];
      REG_MAX_TOKENS: lim_max      = val[31:0];
      REG_BLOCK_THR:  lim_block    = val[31:0];
      REG_ALERT_THR:  lim_alert    = val[31:0];
      REG_INTERVAL:   lim_interval = val[31:0];
      REG_TOKENS_PI:  lim_tpi      = val[31:0];
      REG_COSTS:      lim_costs    = val;
      default: ;
    endcase
  endtask

  task automatic set_limits(logic [31:0] mx, logic [31:0] blk, logic [31:0] alr,
                            logic [31:0] ivl, logic [31:0] tpi, logic [63:0] costs);
    write_reg(REG_MAX_TOKENS, {32'd0, mx});
    write_reg(REG_BLOCK_THR, {32'd0, blk});
    write_reg(REG_ALERT_THR, {32'd0, alr});
    write_reg(REG_INTERVAL, {32'd0, ivl});
    write_reg(REG_TOKENS_PI, {32'd0, tpi});
    write_reg(REG_COSTS, costs);
  endtask

  // Directed: charging, blocking, decay, query, clear, disable, unused command
  task automatic test_directed();
    // costs: +30, +120, -16, 0
    set_limits(32'd1000, 32'd100, 32'd50, 32'd1, 32'd1, 64'h0000_FFF0_0078_001E);
    send_cmd(CMD_QUERY, 10'd5, 2'd0, 32'd0);       // empty bucket
    send_cmd(CMD_CHECK, 10'd5, 2'd3, 32'd0);       // zero cost, no bucket made
    send_cmd(CMD_CHECK, 10'd5, 2'd0, 32'd10);      // create, 30
    send_cmd(CMD_CHECK, 10'd5, 2'd0, 32'd10);      // alert crossing
    send_cmd(CMD_CHECK, 10'd5, 2'd1, 32'd10);      // newly blocked
    send_cmd(CMD_QUERY, 10'd5, 2'd0, 32'd12);      // blocked until
    send_cmd(CMD_CHECK, 10'd5, 2'd3, 32'd13);      // zero cost while blocked
    send_cmd(CMD_QUERY, 10'd5, 2'd0, 32'd500);     // decays to unblocked
    send_cmd(CMD_CHECK, 10'd5, 2'd2, 32'd500);     // negative cost floored
    send_cmd(CMD_CHECK, 10'd1023, 2'd1, 32'hFFFF_FFFF);
    for (int i = 0; i < 12; i++) send_cmd(CMD_CHECK, 10'd1023, 2'd1, 32'hFFFF_FFFF);
    send_cmd(CMD_CHECK, 10'd0, 2'd1, 32'd3);       // new bucket, no decay
    send_cmd(CMD_CLEAR, 10'd1023, 2'd0, 32'd7);
    send_cmd(CMD_CLEAR, 10'd77, 2'd0, 32'd7);      // clear of absent bucket
    send_cmd(2'd3, 10'd5, 2'd1, 32'd9);            // unused command
    drain();
    write_reg(REG_ENABLED, 64'd0);
    send_cmd(CMD_CHECK, 10'd0, 2'd1, 32'd100);
    send_cmd(CMD_CHECK, 10'd9, 2'd1, 32'd100);
    drain();
    write_reg(REG_ENABLED, 64'd1);
  endtask

  // Random stream on a few hot buckets so that buckets fill, block and decay
  task automatic test_random(int count, int hot);
    logic [31:0] clock_s;
    logic [9:0]  idx;
    logic [1:0]  cmd;
    clock_s = $urandom;
    for (int i = 0; i < count; i++) begin
      clock_s = clock_s + ($urandom_range(0, 3) == 0 ? $urandom_range(0, 40) : 0);
      if ($urandom_range(0, 19) == 0) clock_s = $urandom;
      idx = $urandom_range(0, 9) == 0 ? 10'($urandom) : 10'($urandom_range(0, hot - 1));
      case ($urandom_range(0, 19))
        0:            cmd = CMD_CLEAR;
        1:            cmd = 2'd3;
        2, 3, 4, 5:   cmd = CMD_QUERY;
        default:      cmd = CMD_CHECK;
      endcase
      send_cmd(cmd, idx, 2'($urandom), clock_s);
      if (i == count / 2) drain();   // hold off until every result is in
    end
    drain();
  endtask

  // Extreme settings: zero divisors, zero and full-scale thresholds
  task automatic test_extremes();
    set_limits(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0, 64'h8000_7FFF_FFFF_0001);
    test_random(150, 6);
    set_limits(32'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
               64'hFFFF_FFFF_FFFF_FFFF);
    test_random(100, 6);
  endtask

  task automatic test_random_settings();
    for (int p = 0; p < 5; p++) begin
      set_limits($urandom_range(50, 3000), $urandom_range(20, 400), $urandom_range(0, 300),
                 $urandom_range(1, 8), $urandom_range(1, 20),
                 {16'($urandom_range(0, 600)), 16'(-$urandom_range(0, 80)),
                  16'($urandom_range(0, 200)), 16'($urandom_range(0, 60))});
      test_random(210, 8);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    mismatches = 0;
    lim_enabled = 1'b1; lim_max = 32'd1000; lim_block = 32'd100; lim_alert = 32'd50;
    lim_interval = 32'd1; lim_tpi = 32'd1; lim_costs = '0;
    for (int i = 0; i < 1024; i++) begin
      tbl_valid[i] = 1'b0; tbl_tokens[i] = '0; tbl_stamp[i] = '0;
    end
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_extremes();
    test_random_settings();
    drain();
    if (mismatches == 0 && verdict_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[leaky_bucket_rate_limiter_unit.f]
design/lbrl_pkg.sv
design/lbrl_ram.sv
design/lbrl_divider.sv
design/leaky_bucket_rate_limiter_unit.sv
verif/leaky_bucket_rate_limiter_unit_tb.sv
